/* hw/rtl/imap_literal_response_framer_unit_macros.svh */
// ----------------------------------------------------------------------------
// imap literal response framer - assertion macros
// shared concurrent assertion forms, sampled on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef IMAP_LITERAL_RESPONSE_FRAMER_UNIT_MACROS_SVH
`define IMAP_LITERAL_RESPONSE_FRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define IMAPLRF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imaplrf assertion failed");

// next-cycle implication
`define IMAPLRF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imaplrf assertion failed");

`endif

/* hw/rtl/imaplrf_pkg.sv */
// ----------------------------------------------------------------------------
// imaplrf_pkg
// types, widths and character codes for the imap literal response framer
// ----------------------------------------------------------------------------
package imaplrf_pkg;

  localparam int LimitW = 31;
  localparam int CountW = 32;

  typedef logic [7:0] octet_t;

  localparam octet_t CH_LBRACE = 8'h7B;
  localparam octet_t CH_RBRACE = 8'h7D;
  localparam octet_t CH_PLUS   = 8'h2B;
  localparam octet_t CH_CR     = 8'h0D;
  localparam octet_t CH_LF     = 8'h0A;
  localparam octet_t CH_ZERO   = 8'h30;
  localparam octet_t CH_NINE   = 8'h39;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef logic [2:0] sfx_t;
  localparam sfx_t SFX_NONE  = 3'd0;
  localparam sfx_t SFX_OPEN  = 3'd1;
  localparam sfx_t SFX_DIGIT = 3'd2;
  localparam sfx_t SFX_PLUS  = 3'd3;
  localparam sfx_t SFX_CLOSE = 3'd4;
  localparam sfx_t SFX_CR    = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_END_CLEAN = 2'd1;
  localparam status_t ST_END_MID   = 2'd2;
  localparam status_t ST_END_LIT   = 2'd3;

  typedef logic [LimitW-1:0] limit_t;
  typedef logic [CountW-1:0] count_t;

  localparam limit_t LIMIT_RESET = '1;

  typedef struct packed {
    sfx_t   sfx;
    count_t count;
  } scan_t;

endpackage

/* hw/rtl/imaplrf_if.sv */
// ----------------------------------------------------------------------------
// imaplrf channel interfaces
// valid/ready channels for input beats and result beats
// ----------------------------------------------------------------------------
interface imaplrf_in_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  imaplrf_pkg::octet_t  byte_req;

  modport source (output valid, output kind, output byte_req, input ready);
  modport sink   (input valid, input kind, input byte_req, output ready);
endinterface

interface imaplrf_out_if;
  logic                  valid;
  logic                  ready;
  imaplrf_pkg::octet_t   out_byte;
  logic                  is_literal_octet;
  logic                  last_of_response;
  imaplrf_pkg::status_t  status;

  modport source (output valid, output out_byte, output is_literal_octet,
                  output last_of_response, output status, input ready);
  modport sink   (input valid, input out_byte, input is_literal_octet,
                  input last_of_response, input status, output ready);
endinterface

/* hw/rtl/imaplrf_scan.sv */
// ----------------------------------------------------------------------------
// imaplrf_scan
// literal introducer scanner: next suffix state and count for one line octet
// ----------------------------------------------------------------------------
module imaplrf_scan (
  input  imaplrf_pkg::octet_t octet,
  input  imaplrf_pkg::scan_t  cur,
  output imaplrf_pkg::scan_t  nxt
);
  import imaplrf_pkg::*;

  localparam int ProdW = CountW + 4;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ProdW-1:0] prod;

  assign is_digit = (octet >= CH_ZERO) && (octet <= CH_NINE);
  assign digit    = 4'(octet - CH_ZERO);
  // count * 10 + digit as two shifts and an add
  assign prod     = (ProdW'(cur.count) << 3) + (ProdW'(cur.count) << 1) + ProdW'(digit);

  always_comb begin
    nxt = cur;
    priority if (octet == CH_LBRACE) begin
      nxt.sfx   = SFX_OPEN;
      nxt.count = '0;
    end else if (is_digit) begin
      if (cur.sfx == SFX_OPEN || cur.sfx == SFX_DIGIT) begin
        nxt.sfx   = SFX_DIGIT;
        nxt.count = (|prod[ProdW-1:CountW]) ? '1 : prod[CountW-1:0];
      end else begin
        nxt.sfx = SFX_NONE;
      end
    end else if (octet == CH_PLUS) begin
      nxt.sfx = (cur.sfx == SFX_DIGIT) ? SFX_PLUS : SFX_NONE;
    end else if (octet == CH_RBRACE) begin
      nxt.sfx = (cur.sfx == SFX_DIGIT || cur.sfx == SFX_PLUS) ? SFX_CLOSE : SFX_NONE;
    end else if (octet == CH_CR) begin
      nxt.sfx = (cur.sfx == SFX_CLOSE) ? SFX_CR : SFX_NONE;
    end else begin
      nxt.sfx = SFX_NONE;
    end
  end

endmodule

/* hw/rtl/imap_literal_response_framer_unit.sv */
// ----------------------------------------------------------------------------
// imap literal response framer
// an accepted beat is held in the input register, then registered in the result register
// one beat per cycle while the result channel does not stall, set by the scanner and state update
// an input register and a result register decouple the two channels
// reset: clears scanner, literal and pending state, sets literal_limit to max
// ----------------------------------------------------------------------------
module imap_literal_response_framer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  imaplrf_in_if.sink                   in_ch,
  imaplrf_out_if.source                out_ch,
  input  logic                         cfg_we,
  input  logic [imaplrf_pkg::LimitW-1:0] cfg_wdata
);
  import imaplrf_pkg::*;

  // config
  limit_t  limit_r;

  // input register
  logic    s1_vld_r;
  logic    s1_kind_r;
  octet_t  s1_byte_r;

  // framer state
  logic    in_lit_r,  in_lit_nxt;
  sfx_t    sfx_r,     sfx_nxt;
  count_t  cnt_r,     cnt_nxt;
  limit_t  left_r,    left_nxt;
  logic    line_r,    line_nxt;
  logic    resp_r,    resp_nxt;

  // result register
  logic    out_vld_r;
  octet_t  out_byte_r,   res_byte;
  logic    out_lit_r,    res_lit;
  logic    out_last_r,   res_last;
  status_t out_status_r, res_status;

  logic    out_free;
  logic    advance;
  logic    has_lit;
  scan_t   scan_cur;
  scan_t   scan_nxt;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign advance     = s1_vld_r && out_free;
  assign in_ch.ready = !s1_vld_r || out_free;

  assign scan_cur.sfx   = sfx_r;
  assign scan_cur.count = cnt_r;

  imaplrf_scan u_scan (
    .octet (s1_byte_r),
    .cur   (scan_cur),
    .nxt   (scan_nxt)
  );

  assign has_lit = (sfx_r == SFX_CLOSE || sfx_r == SFX_CR) &&
                   (cnt_r <= CountW'(limit_r));

  always_comb begin
    in_lit_nxt = in_lit_r;
    sfx_nxt    = sfx_r;
    cnt_nxt    = cnt_r;
    left_nxt   = left_r;
    line_nxt   = line_r;
    resp_nxt   = resp_r;
    res_byte   = '0;
    res_lit    = 1'b0;
    res_last   = 1'b0;
    res_status = ST_OK;
    if (s1_kind_r == KIND_END) begin
      priority if (in_lit_r) begin
        res_status = ST_END_LIT;
      end else if (line_r) begin
        res_byte = CH_LF;
        if (has_lit) begin
          res_status = (cnt_r == '0) ? ST_END_MID : ST_END_LIT;
        end else begin
          res_last   = 1'b1;
          res_status = ST_END_CLEAN;
        end
      end else begin
        res_status = resp_r ? ST_END_MID : ST_END_CLEAN;
      end
      in_lit_nxt = 1'b0;
      sfx_nxt    = SFX_NONE;
      cnt_nxt    = '0;
      left_nxt   = '0;
      line_nxt   = 1'b0;
      resp_nxt   = 1'b0;
    end else if (in_lit_r) begin
      res_byte = s1_byte_r;
      res_lit  = 1'b1;
      if (left_r != '0) begin
        left_nxt = left_r - 1'b1;
      end
      if (left_r <= LimitW'(1)) begin
        in_lit_nxt = 1'b0;
        sfx_nxt    = SFX_NONE;
        cnt_nxt    = '0;
        line_nxt   = 1'b0;
      end
    end else begin
      res_byte = s1_byte_r;
      resp_nxt = 1'b1;
      if (s1_byte_r == CH_LF) begin
        if (has_lit) begin
          if (cnt_r != '0) begin
            in_lit_nxt = 1'b1;
            left_nxt   = cnt_r[LimitW-1:0];
          end
        end else begin
          res_last = 1'b1;
          resp_nxt = 1'b0;
        end
        sfx_nxt  = SFX_NONE;
        cnt_nxt  = '0;
        line_nxt = 1'b0;
      end else begin
        line_nxt = 1'b1;
        sfx_nxt  = scan_nxt.sfx;
        cnt_nxt  = scan_nxt.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_kind_r <= in_ch.kind;
      s1_byte_r <= in_ch.byte_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_lit_r <= 1'b0;
      sfx_r    <= SFX_NONE;
      cnt_r    <= '0;
      left_r   <= '0;
      line_r   <= 1'b0;
      resp_r   <= 1'b0;
    end else if (advance) begin
      in_lit_r <= in_lit_nxt;
      sfx_r    <= sfx_nxt;
      cnt_r    <= cnt_nxt;
      left_r   <= left_nxt;
      line_r   <= line_nxt;
      resp_r   <= resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r   <= res_byte;
      out_lit_r    <= res_lit;
      out_last_r   <= res_last;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.out_byte         = out_byte_r;
  assign out_ch.is_literal_octet = out_lit_r;
  assign out_ch.last_of_response = out_last_r;
  assign out_ch.status           = out_status_r;

endmodule

/* hw/rtl/imaplrf_chk.sv */
// ----------------------------------------------------------------------------
// imaplrf_chk
// port-level checks on the result channel of the framer, bound to the top level
// ----------------------------------------------------------------------------
`include "imap_literal_response_framer_unit_macros.svh"

module imaplrf_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input imaplrf_pkg::octet_t  out_byte,
  input logic                 out_lit,
  input logic                 out_last,
  input imaplrf_pkg::status_t out_status
);
  import imaplrf_pkg::*;

  logic [11:0] beat;

  assign beat = {out_byte, out_lit, out_last, out_status};

  // stalled beat holds
  `IMAPLRF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(beat))

  // no result beat straight out of reset
  `IMAPLRF_ASSERT_IMPL(a_reset_empty, $past(!rst_n), !out_valid)

  // a response only ends on an lf, real or synthetic
  `IMAPLRF_ASSERT_IMPL(a_last_on_lf, out_valid && out_last, out_byte == CH_LF && !out_lit)

  // literal octets are plain data beats
  `IMAPLRF_ASSERT_IMPL(a_lit_is_data, out_valid && out_lit, out_status == ST_OK && !out_last)

endmodule

bind imap_literal_response_framer_unit imaplrf_chk u_imaplrf_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .out_lit    (out_ch.is_literal_octet),
  .out_last   (out_ch.last_of_response),
  .out_status (out_ch.status)
);
